>>> src/text_console_writer_macros.svh
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcw_pkg.sv
// shared constants, types and helpers of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int MOVE_CNT = (ROWS - 1) * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int TGT_W     = 8;
    localparam int CADDR_W   = 11;
    localparam int POS_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    typedef struct packed {
        logic  valid;
        logic  busy;
        t_row  row;
        t_col  col;
        t_addr pos;
        t_cell data;
    } t_status;

    function automatic t_addr cell_index(t_row row, t_col col);
        return ADDR_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

endpackage

>>> src/tcw_screen_mem.sv
// screen cell memory, one write and one registered read port
`timescale 1ns / 1ps

module tcw_screen_mem (
    input  logic              i_clk,
    input  tcw_pkg::t_mem_req i_req,
    output tcw_pkg::t_cell    o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [CELLS];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tcw_ctrl.sv
// command sequencer: cursor, attribute, scroll copy and fill sweeps
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tcw_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::TGT_W-1:0]        i_target_row,
    input  logic [tcw_pkg::TGT_W-1:0]        i_target_column,
    input  logic [tcw_pkg::CADDR_W-1:0]      i_cell_address,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       i_cfg_wdata,
    input  tcw_pkg::t_cell                   i_rdata,
    output tcw_pkg::t_mem_req                o_mem_req,
    output tcw_pkg::t_status                 o_status
);
    import tcw_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_BLANK  = 2'd3;

    localparam t_row ROW_LAST = ROW_W'(ROWS - 1);
    localparam t_col COL_LAST = COL_W'(COLUMNS - 1);

    logic [1:0]        r_state, n_state;
    t_addr             r_cnt, n_cnt;
    t_row              r_row, n_row;
    t_col              r_col, n_col;
    t_cell             r_fill, n_fill;
    logic              r_emit, n_emit;
    logic              r_valid, n_valid;
    logic [ATTR_W-1:0] r_attr;
    t_cell             r_data, n_data;
    logic              r_rd_ok, n_rd_ok;
    logic              go_scroll;
    t_cell             blank;
    t_mem_req          req;

    assign blank = {r_attr, CH_SPACE};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_row     = r_row;
        n_col     = r_col;
        n_fill    = r_fill;
        n_emit    = r_emit;
        n_rd_ok   = r_rd_ok;
        n_valid   = 1'b0;
        n_data    = '0;
        go_scroll = 1'b0;
        req       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_PUT: begin
                            if (i_char_code == CH_NEWLINE) begin
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    go_scroll = 1'b1;
                                end else begin
                                    n_row = r_row + ROW_W'(1);
                                end
                            end else if (i_char_code == CH_RETURN) begin
                                n_col = '0;
                            end else if (i_char_code == CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col     = r_col - COL_W'(1);
                                    req.we    = 1'b1;
                                    req.waddr = cell_index(r_row, r_col - COL_W'(1));
                                    req.wdata = blank;
                                end
                            end else begin
                                req.we    = 1'b1;
                                req.waddr = cell_index(r_row, r_col);
                                req.wdata = {r_attr, i_char_code};
                                if (r_col == COL_LAST) begin
                                    n_col = '0;
                                    if (r_row == ROW_LAST) begin
                                        go_scroll = 1'b1;
                                    end else begin
                                        n_row = r_row + ROW_W'(1);
                                    end
                                end else begin
                                    n_col = r_col + COL_W'(1);
                                end
                            end
                            if (go_scroll) begin
                                n_state = S_SCROLL;
                                n_cnt   = '0;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        CMD_SET: begin
                            n_row   = (i_target_row < ROWS) ? ROW_W'(i_target_row) : ROW_LAST;
                            n_col   = (i_target_column < COLUMNS) ?
                                      COL_W'(i_target_column) : COL_LAST;
                            n_valid = 1'b1;
                        end
                        CMD_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_state = S_BLANK;
                            n_cnt   = '0;
                            n_fill  = blank;
                            n_emit  = 1'b1;
                        end
                        default: begin
                            req.re    = 1'b1;
                            req.raddr = ADDR_W'(i_cell_address);
                            n_rd_ok   = (i_cell_address < CELLS);
                            n_state   = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_data  = r_rd_ok ? i_rdata : '0;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                // read one row ahead, write the previous cycle's data one row up
                if (r_cnt < ADDR_W'(MOVE_CNT)) begin
                    req.re    = 1'b1;
                    req.raddr = r_cnt + ADDR_W'(COLUMNS);
                end
                if (r_cnt != '0) begin
                    req.we    = 1'b1;
                    req.waddr = r_cnt - ADDR_W'(1);
                    req.wdata = i_rdata;
                end
                if (r_cnt == ADDR_W'(MOVE_CNT)) begin
                    n_state = S_BLANK;
                    n_fill  = blank;
                    n_emit  = 1'b1;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_BLANK: begin
                req.we    = 1'b1;
                req.waddr = r_cnt;
                req.wdata = r_fill;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_valid = r_emit;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BLANK;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_fill  <= RESET_BLANK;
            r_emit  <= 1'b0;
            r_valid <= 1'b0;
            r_attr  <= RESET_ATTR;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_rd_ok <= n_rd_ok;
    end

    assign o_mem_req       = req;
    assign o_status.valid  = r_valid;
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.row    = r_row;
    assign o_status.col    = r_col;
    assign o_status.pos    = cell_index(r_row, r_col);
    assign o_status.data   = r_data;

endmodule

>>> src/text_console_writer.sv
// text console writer top level
//
//  channel   direction  handshake                  payload
//  command   in         start, busy                i_cmd, i_char_code, i_target_row,
//                                                  i_target_column, i_cell_address
//  result    out        o_result_valid (strobe)    o_cursor_position, o_cursor_row,
//                                                  o_cursor_column, o_cell_data
//  config    in         i_cfg_we                   i_cfg_wdata (text attribute)
//
// set cursor and a non-scrolling put: the result strobes the next cycle and busy stays low.
// read cell goes through the registered read port of the screen memory and the S_READ state,
// with busy high, before its result strobes. a put that scrolls holds busy through a sweep
// that copies every row but the first one row up and a sweep that blanks the last row; clear
// screen holds busy while it blanks every cell. after reset a clearing pass holds busy high.
// results are shown for one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tcw_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::TGT_W-1:0]        i_target_row,
    input  logic [tcw_pkg::TGT_W-1:0]        i_target_column,
    input  logic [tcw_pkg::CADDR_W-1:0]      i_cell_address,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]       i_cfg_wdata,
    output logic                             o_result_valid,
    output logic [tcw_pkg::POS_W-1:0]        o_cursor_position,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    o_cursor_column,
    output logic [tcw_pkg::CELL_W-1:0]       o_cell_data
);
    import tcw_pkg::*;

    t_mem_req mem_req;
    t_cell    rdata;
    t_status  st;

    tcw_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_cmd           (i_cmd),
        .i_char_code     (i_char_code),
        .i_target_row    (i_target_row),
        .i_target_column (i_target_column),
        .i_cell_address  (i_cell_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rdata         (rdata),
        .o_mem_req       (mem_req),
        .o_status        (st)
    );

    tcw_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign busy              = st.busy;
    assign o_result_valid    = st.valid;
    assign o_cursor_position = POS_W'(st.pos);
    assign o_cursor_row      = ROW_OUT_W'(st.row);
    assign o_cursor_column   = COL_OUT_W'(st.col);
    assign o_cell_data       = st.data;

    `TCW_ASSERT_SAME(a_cursor_range, st.valid, (st.row <= ROW_W'(ROWS - 1)) && (st.col <= COL_W'(COLUMNS - 1)), "cursor out of range on result")
    `TCW_ASSERT_NEXT(a_read_waits, start && !busy && (i_cmd == CMD_READ), busy && !o_result_valid, "read cell did not wait for memory data")
    `TCW_ASSERT_SAME(a_write_range, mem_req.we, mem_req.waddr <= ADDR_W'(CELLS - 1), "memory write beyond screen")
    `TCW_ASSERT_SAME(a_copy_apart, mem_req.we && mem_req.re, mem_req.raddr != mem_req.waddr, "scroll read and write hit the same cell")

endmodule

>>> tb/text_console_writer_tb.sv
// self-checking testbench for the text console writer: screen model, directed and random commands
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int LIMIT_CYCLES    = 6_000_000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int MAX_GAP         = 200;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAR_W-1:0]  ch;
        logic [TGT_W-1:0]   trow;
        logic [TGT_W-1:0]   tcol;
        logic [CADDR_W-1:0] addr;
    } t_console_cmd;

    typedef struct packed {
        logic [POS_W-1:0]     pos;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    data;
    } t_cursor_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = CMD_PUT;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic [TGT_W-1:0]     i_target_row = '0;
    logic [TGT_W-1:0]     i_target_column = '0;
    logic [CADDR_W-1:0]   i_cell_address = '0;
    logic                 i_cfg_we = 1'b0;
    logic [ATTR_W-1:0]    i_cfg_wdata = '0;
    logic                 o_result_valid;
    logic [POS_W-1:0]     o_cursor_position;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [COL_OUT_W-1:0] o_cursor_column;
    logic [CELL_W-1:0]    o_cell_data;

    logic [CELL_W-1:0] screen_model [CELLS];
    int                model_row;
    int                model_col;
    logic [ATTR_W-1:0] model_attr;

    t_cursor_result pending_results [$];
    t_cursor_result oldest_result;
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             sender_idle_pct = 0;

    text_console_writer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_char_code       (i_char_code),
        .i_target_row      (i_target_row),
        .i_target_column   (i_target_column),
        .i_cell_address    (i_cell_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_result_valid    (o_result_valid),
        .o_cursor_position (o_cursor_position),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_column   (o_cursor_column),
        .o_cell_data       (o_cell_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // screen model

    function automatic void advance_line();
        int i;
        model_col = 0;
        model_row++;
        if (model_row >= ROWS) begin
            for (i = 0; i < MOVE_CNT; i++) begin
                screen_model[i] = screen_model[i + COLUMNS];
            end
            for (i = MOVE_CNT; i < CELLS; i++) begin
                screen_model[i] = {model_attr, CH_SPACE};
            end
            model_row = ROWS - 1;
        end
    endfunction

    function automatic t_cursor_result predict_cursor(t_console_cmd c);
        t_cursor_result r;
        int i;
        r.data = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.ch == CH_NEWLINE) begin
                    advance_line();
                end else if (c.ch == CH_RETURN) begin
                    model_col = 0;
                end else if (c.ch == CH_BACKSPACE) begin
                    if (model_col > 0) begin
                        model_col--;
                        screen_model[model_row * COLUMNS + model_col] = {model_attr, CH_SPACE};
                    end
                end else begin
                    screen_model[model_row * COLUMNS + model_col] = {model_attr, c.ch};
                    model_col++;
                    if (model_col >= COLUMNS) begin
                        advance_line();
                    end
                end
            end
            CMD_SET: begin
                model_row = (c.trow < ROWS) ? int'(c.trow) : ROWS - 1;
                model_col = (c.tcol < COLUMNS) ? int'(c.tcol) : COLUMNS - 1;
            end
            CMD_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    screen_model[i] = {model_attr, CH_SPACE};
                end
                model_row = 0;
                model_col = 0;
            end
            CMD_READ: begin
                if (c.addr < CELLS) begin
                    r.data = screen_model[c.addr];
                end
            end
            default: begin
            end
        endcase
        r.pos = POS_W'(model_row * COLUMNS + model_col);
        r.row = ROW_OUT_W'(model_row);
        r.col = COL_OUT_W'(model_col);
        return r;
    endfunction

    // command builders

    function automatic t_console_cmd noise_cmd();
        t_console_cmd c;
        c.cmd  = CMD_W'($urandom_range(3));
        c.ch   = CHAR_W'($urandom_range(255));
        c.trow = TGT_W'($urandom_range(255));
        c.tcol = TGT_W'($urandom_range(255));
        c.addr = CADDR_W'($urandom_range((1 << CADDR_W) - 1));
        return c;
    endfunction

    function automatic t_console_cmd put_cmd(logic [CHAR_W-1:0] ch);
        t_console_cmd c;
        c = noise_cmd();
        c.cmd = CMD_PUT;
        c.ch = ch;
        return c;
    endfunction

    function automatic t_console_cmd set_cmd(int row, int col);
        t_console_cmd c;
        c = noise_cmd();
        c.cmd = CMD_SET;
        c.trow = TGT_W'(row);
        c.tcol = TGT_W'(col);
        return c;
    endfunction

    function automatic t_console_cmd read_cmd(int addr);
        t_console_cmd c;
        c = noise_cmd();
        c.cmd = CMD_READ;
        c.addr = CADDR_W'(addr);
        return c;
    endfunction

    function automatic t_console_cmd clear_cmd();
        t_console_cmd c;
        c = noise_cmd();
        c.cmd = CMD_CLEAR;
        return c;
    endfunction

    function automatic t_console_cmd random_command();
        int sel;
        int k;
        sel = $urandom_range(99);
        if (sel < 50) begin
            k = $urandom_range(19);
            if (k < 2) begin
                return put_cmd(CH_NEWLINE);
            end else if (k == 2) begin
                return put_cmd(CH_RETURN);
            end else if (k < 5) begin
                return put_cmd(CH_BACKSPACE);
            end
            return put_cmd(CHAR_W'($urandom_range(255)));
        end else if (sel < 72) begin
            return set_cmd($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(ROWS - 1),
                           $urandom_range(3) == 0 ? $urandom_range(255)
                                                  : $urandom_range(COLUMNS - 1));
        end else if (sel < 98) begin
            k = $urandom_range(99);
            if (k < 35) begin
                return read_cmd(model_row * COLUMNS + $urandom_range(COLUMNS - 1));
            end else if (k < 85) begin
                return read_cmd($urandom_range(CELLS - 1));
            end
            return read_cmd($urandom_range((1 << CADDR_W) - 1));
        end
        return clear_cmd();
    endfunction

    // driving

    task automatic drive_fields(input t_console_cmd c);
        i_cmd           <= c.cmd;
        i_char_code     <= c.ch;
        i_target_row    <= c.trow;
        i_target_column <= c.tcol;
        i_cell_address  <= c.addr;
    endtask

    task automatic send_command(input t_console_cmd c);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            drive_fields(noise_cmd());
            repeat (gap) @(posedge i_clk);
        end
        drive_fields(c);
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_cursor(c));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_attr = value;
    endtask

    // checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at cycle %0d: got %0h expected %0h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("text_console_writer_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_cursor_position, 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_cursor_position !== oldest_result.pos)
                    report_mismatch("cursor_position", o_cursor_position, oldest_result.pos);
                if (o_cursor_row !== oldest_result.row)
                    report_mismatch("cursor_row", o_cursor_row, oldest_result.row);
                if (o_cursor_column !== oldest_result.col)
                    report_mismatch("cursor_column", o_cursor_column, oldest_result.col);
                if (o_cell_data !== oldest_result.data)
                    report_mismatch("cell_data", o_cell_data, oldest_result.data);
            end
        end
    end

    // tests

    task automatic test_reset_screen();
        send_command(read_cmd(0));
        send_command(read_cmd(CELLS - 1));
        send_command(read_cmd(CELLS));
        send_command(read_cmd((1 << CADDR_W) - 1));
    endtask

    task automatic test_control_chars();
        send_command(put_cmd(8'h41));
        send_command(put_cmd(8'hFF));
        send_command(put_cmd(8'h00));
        send_command(put_cmd(CH_BACKSPACE));
        send_command(put_cmd(CH_BACKSPACE));
        send_command(put_cmd(CH_BACKSPACE));
        send_command(put_cmd(CH_BACKSPACE));
        send_command(put_cmd(8'h7E));
        send_command(put_cmd(CH_RETURN));
        send_command(put_cmd(CH_NEWLINE));
        send_command(read_cmd(0));
        send_command(read_cmd(1));
    endtask

    task automatic test_wrap_and_scroll();
        send_command(set_cmd(255, 255));
        send_command(put_cmd(8'h5A));
        send_command(read_cmd(MOVE_CNT - 1));
        send_command(read_cmd(CELLS - 1));
        send_command(set_cmd(ROWS - 1, 0));
        send_command(put_cmd(CH_NEWLINE));
        send_command(set_cmd(3, 200));
    endtask

    task automatic test_attribute_and_clear();
        drain_results();
        write_attribute(8'hFF);
        send_command(set_cmd(10, 10));
        send_command(put_cmd(8'h78));
        send_command(read_cmd(10 * COLUMNS + 10));
        send_command(clear_cmd());
        send_command(read_cmd(CELLS - 1));
        drain_results();
        write_attribute(8'h00);
        send_command(put_cmd(8'h80));
        send_command(read_cmd(0));
    endtask

    task automatic test_random_traffic(input int idle_pct, input logic [ATTR_W-1:0] attr);
        drain_results();
        write_attribute(attr);
        sender_idle_pct = idle_pct;
        repeat (ITEMS_PER_PHASE) send_command(random_command());
    endtask

    initial begin
        int i;
        for (i = 0; i < CELLS; i++) begin
            screen_model[i] = RESET_BLANK;
        end
        model_row = 0;
        model_col = 0;
        model_attr = RESET_ATTR;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        test_reset_screen();
        test_control_chars();
        test_wrap_and_scroll();
        test_attribute_and_clear();
        test_random_traffic(0, ATTR_W'($urandom_range(255)));
        test_random_traffic(86, 8'hFF);
        test_random_traffic(0, 8'h00);
        test_random_traffic(17, RESET_ATTR);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("text_console_writer_tb passed");
        end else begin
            $display("text_console_writer_tb failed");
        end
        $finish;
    end

endmodule
